>>> design/etfp_pkg.sv
`timescale 1ns / 1ps

package etfp_pkg;

	// Number format and field widths
	localparam int FRAC_BITS = 28;
	localparam int DATA_W    = 32;
	localparam int COORD_W   = 12;
	localparam int STEP_W    = 31;
	localparam int LIMIT_W   = 16;
	localparam int COUNT_W   = 8;
	localparam int ROWS_W    = 13;
	localparam int MAP_W     = COORD_W + STEP_W;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int CFG_IDX_W = 3;

	// Iteration cells in the ring
	localparam int DEF_CELLS = 2;

	// Escape bound: a*a + b*b < 4.0, taken on the unshifted squares
	localparam int               ESC_SHIFT  = 2 * FRAC_BITS + 2;
	localparam bit               ESC_ALWAYS = (ESC_SHIFT >= PROD_W);
	localparam logic [PROD_W-1:0] ESC_BOUND =
		ESC_ALWAYS ? '0 : (PROD_W'(1) << ESC_SHIFT);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JULIA_MODE = 3'd0,
		REG_ORIGIN_X   = 3'd1,
		REG_ORIGIN_Y   = 3'd2,
		REG_PIXEL_STEP = 3'd3,
		REG_ITER_LIMIT = 3'd4,
		REG_CONST_RE   = 3'd5,
		REG_CONST_IM   = 3'd6,
		REG_IMAGE_ROWS = 3'd7
	} reg_idx_t;

	// One pixel in flight through the ring
	typedef struct packed {
		logic                     valid;
		logic                     done;
		logic signed [DATA_W-1:0] za;
		logic signed [DATA_W-1:0] zb;
		logic [LIMIT_W-1:0]       step;
	} tok_t;

	// Per-pixel settings shared by all cells
	typedef struct packed {
		logic signed [DATA_W-1:0] c_re;
		logic signed [DATA_W-1:0] c_im;
		logic [LIMIT_W-1:0]       limit;
	} cell_cfg_t;

	// Clamp a wide signed value to the data range
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
			r = v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> design/escape_time_fractal_pixel_unit.sv
`timescale 1ns / 1ps
// Index times step is registered on accept, then the mapped pixel enters a ring of CELLS
// iteration cells (n iterations take n+1 passes, rounded up to a full lap), each a two-stage
// multiply/accumulate loop; the count is held, then registered for output. One pixel at a
// time: a new request waits until the last has left the ring; a finished result waits in
// the output register while the next request is taken. Reset: asynchronous, active low,
// clears control state and loads the register defaults (Mandelbrot, -2.0 origin, 255 limit).

module escape_time_fractal_pixel_unit import etfp_pkg::*; #(
	parameter int CELLS = DEF_CELLS
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COORD_W-1:0]   column,
	input  logic [COORD_W-1:0]   row,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COORD_W-1:0]   out_column,
	output logic [COORD_W-1:0]   screen_row,
	output logic [COUNT_W-1:0]   escape_count
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MAP  = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic                     julia_q;
	logic signed [DATA_W-1:0] origin_x_q;
	logic signed [DATA_W-1:0] origin_y_q;
	logic [STEP_W-1:0]        pixel_step_q;
	logic [LIMIT_W-1:0]       iter_limit_q;
	logic signed [DATA_W-1:0] const_re_q;
	logic signed [DATA_W-1:0] const_im_q;
	logic [ROWS_W-1:0]        image_rows_q;

	// Request held for the whole pixel
	logic [COORD_W-1:0]       col_q;
	logic [COORD_W-1:0]       row_q;
	logic [MAP_W-1:0]         map_re_c;
	logic [MAP_W-1:0]         map_im_c;
	logic [MAP_W-1:0]         map_re_s1;
	logic [MAP_W-1:0]         map_im_s1;
	logic signed [SUM_W-1:0]  pt_re_wide;
	logic signed [SUM_W-1:0]  pt_im_wide;
	logic signed [DATA_W-1:0] pt_re;
	logic signed [DATA_W-1:0] pt_im;
	logic signed [DATA_W-1:0] c_re_q;
	logic signed [DATA_W-1:0] c_im_q;
	logic [COUNT_W-1:0]       res_count_q;

	// Ring of iteration cells
	tok_t      ring [CELLS+1];
	tok_t      start_tok;
	tok_t      lap_end;
	cell_cfg_t cell_cfg;
	logic      accept_in;
	logic      finish;
	logic      out_free;

	logic                     out_valid_q;
	logic [COORD_W-1:0]       out_column_q;
	logic [COORD_W-1:0]       screen_row_q;
	logic [COUNT_W-1:0]       escape_count_q;

	// Register writes; the user must issue them only while the unit is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia_q      <= 1'b0;
			origin_x_q   <= 32'hE000_0000;
			origin_y_q   <= 32'hE000_0000;
			pixel_step_q <= STEP_W'(268435);
			iter_limit_q <= LIMIT_W'(255);
			const_re_q   <= '0;
			const_im_q   <= '0;
			image_rows_q <= ROWS_W'(4096);
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_JULIA_MODE: julia_q      <= cfg_data[0];
				REG_ORIGIN_X:   origin_x_q   <= cfg_data;
				REG_ORIGIN_Y:   origin_y_q   <= cfg_data;
				REG_PIXEL_STEP: pixel_step_q <= cfg_data[STEP_W-1:0];
				REG_ITER_LIMIT: iter_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_CONST_RE:   const_re_q   <= cfg_data;
				REG_CONST_IM:   const_im_q   <= cfg_data;
				REG_IMAGE_ROWS: image_rows_q <= cfg_data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Take a new request only when the ring is empty
	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;

	// Map the pixel: index times step now, add the origin and clamp next cycle
	always_comb begin
		map_re_c = column * pixel_step_q;
		map_im_c = row * pixel_step_q;
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			col_q     <= column;
			row_q     <= row;
			map_re_s1 <= map_re_c;
			map_im_s1 <= map_im_c;
		end
	end

	always_comb begin
		pt_re_wide = $signed({{(SUM_W-MAP_W){1'b0}}, map_re_s1})
			+ $signed({{(SUM_W-DATA_W){origin_x_q[DATA_W-1]}}, origin_x_q});
		pt_im_wide = $signed({{(SUM_W-MAP_W){1'b0}}, map_im_s1})
			+ $signed({{(SUM_W-DATA_W){origin_y_q[DATA_W-1]}}, origin_y_q});
		pt_re = sat_data(pt_re_wide);
		pt_im = sat_data(pt_im_wide);
	end

	// Julia starts from the point with a fixed constant; Mandelbrot starts from zero
	always_comb begin
		start_tok.valid = 1'b1;
		start_tok.done  = 1'b0;
		start_tok.za    = julia_q ? pt_re : '0;
		start_tok.zb    = julia_q ? pt_im : '0;
		start_tok.step  = '0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MAP) begin
			c_re_q <= julia_q ? const_re_q : pt_re;
			c_im_q <= julia_q ? const_im_q : pt_im;
		end
	end

	assign cell_cfg = '{c_re: c_re_q, c_im: c_im_q, limit: iter_limit_q};

	// Inject on map, recirculate an unfinished token, otherwise feed a bubble
	assign lap_end = ring[CELLS];
	assign finish  = (state_q == ST_RUN) && lap_end.valid && lap_end.done;

	always_comb begin
		if (state_q == ST_MAP) begin
			ring[0] = start_tok;
		end else if (lap_end.valid && !lap_end.done) begin
			ring[0] = lap_end;
		end else begin
			ring[0] = '0;
		end
	end

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		etfp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cell_cfg),
			.tok_in  (ring[i]),
			.tok_out (ring[i+1])
		);
	end

	// Hold the count until the output register is free
	always_ff @(posedge clk) begin
		if (finish) begin
			res_count_q <= lap_end.step[COUNT_W-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept_in) state_q <= ST_MAP;
				ST_MAP:  state_q <= ST_RUN;
				ST_RUN:  if (finish) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load on completion, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_column_q   <= col_q;
			screen_row_q   <= image_rows_q[COORD_W-1:0] - COORD_W'(1) - row_q;
			escape_count_q <= res_count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_column   = out_column_q;
	assign screen_row   = screen_row_q;
	assign escape_count = escape_count_q;

endmodule

>>> design/etfp_cell.sv
`timescale 1ns / 1ps

module etfp_cell import etfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cfg_t cfg,
	input  tok_t      tok_in,
	output tok_t      tok_out
);

	logic signed [DATA_W-1:0] za;
	logic signed [DATA_W-1:0] zb;
	logic signed [PROD_W-1:0] aa_c;
	logic signed [PROD_W-1:0] bb_c;
	logic signed [PROD_W-1:0] ab_c;

	logic                     valid_s1;
	logic                     done_s1;
	logic [LIMIT_W-1:0]       step_s1;
	logic signed [PROD_W-1:0] aa_s1;
	logic signed [PROD_W-1:0] bb_s1;
	logic signed [PROD_W-1:0] ab_s1;

	logic [PROD_W-1:0]        mag;
	logic                     in_disc;
	logic                     go;
	logic signed [PROD_W-1:0] diff;
	logic signed [PROD_W-1:0] re_sh;
	logic signed [PROD_W-1:0] im_sh;
	logic signed [SUM_W-1:0]  re_sum;
	logic signed [SUM_W-1:0]  im_sum;
	logic signed [DATA_W-1:0] c_re;
	logic signed [DATA_W-1:0] c_im;

	logic                     valid_s2;
	logic                     done_s2;
	logic [LIMIT_W-1:0]       step_s2;
	logic signed [DATA_W-1:0] za_s2;
	logic signed [DATA_W-1:0] zb_s2;

	// Stage 1: squares and cross product of the current z
	always_comb begin
		za   = tok_in.za;
		zb   = tok_in.zb;
		aa_c = za * za;
		bb_c = zb * zb;
		ab_c = za * zb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		done_s1 <= tok_in.done;
		step_s1 <= tok_in.step;
		aa_s1   <= aa_c;
		bb_s1   <= bb_c;
		ab_s1   <= ab_c;
	end

	// Stage 2: escape test on the exact squares, then the next z
	always_comb begin
		c_re    = cfg.c_re;
		c_im    = cfg.c_im;
		mag     = aa_s1 + bb_s1;
		in_disc = ESC_ALWAYS || (mag < ESC_BOUND);
		go      = !done_s1 && in_disc && (step_s1 < cfg.limit);
		diff    = aa_s1 - bb_s1;
		re_sh   = diff >>> FRAC_BITS;
		im_sh   = ab_s1 >>> (FRAC_BITS - 1);
		re_sum  = SUM_W'(re_sh) + SUM_W'(c_re);
		im_sum  = SUM_W'(im_sh) + SUM_W'(c_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		done_s2 <= !go;
		step_s2 <= go ? step_s1 + LIMIT_W'(1) : step_s1;
		za_s2   <= sat_data(re_sum);
		zb_s2   <= sat_data(im_sum);
	end

	assign tok_out = '{valid: valid_s2, done: done_s2, za: za_s2, zb: zb_s2, step: step_s2};

endmodule
